/* hdl/frp_pkg.sv */
// Shared types and constants for the FASTQ record parser.
package frp_pkg;

	localparam logic [2:0] PH_HDR  = 3'd0;
	localparam logic [2:0] PH_NAME = 3'd1;
	localparam logic [2:0] PH_SEQ  = 3'd2;
	localparam logic [2:0] PH_PLUS = 3'd3;
	localparam logic [2:0] PH_QUAL = 3'd4;
	localparam logic [2:0] PH_HALT = 3'd5;

	localparam logic [2:0] TAG_NONE = 3'd0;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOAT     = 3'd1;
	localparam logic [2:0] ST_MISMATCH = 3'd2;
	localparam logic [2:0] ST_TRUNC    = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;

	localparam logic [7:0] CH_AT = 8'h40;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	localparam int QUEUE_DEPTH = 4;
	localparam int QIDX_BITS   = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic [2:0] tag;
		logic       done;
		logic [2:0] status;
	} result_t;

	// Everything one input beat produces: one or two results.
	typedef struct packed {
		result_t     r0;
		result_t     r1;
		logic        two;
		logic [31:0] seen;
	} entry_t;

endpackage

/* hdl/frp_front.sv */
// Front end: classifies each input byte, keeps parser state, builds queue entries.
module frp_front import frp_pkg::*; #(
	parameter int LENGTH_BITS = 16,
	parameter int COUNT_BITS  = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       end_of_input,
	output logic       wr_en,
	output entry_t     wr_entry
);

	logic [2:0]             phase_q, phase_d;
	logic                   als_q, als_d;
	logic                   pcr_q, pcr_d;
	logic [LENGTH_BITS-1:0] seq_q, seq_d;
	logic [LENGTH_BITS-1:0] qual_q, qual_d;
	logic [COUNT_BITS-1:0]  total_q, total_d;
	logic [2:0]             halt_q, halt_d;
	result_t                res [0:1];
	logic [1:0]             cnt;
	logic                   slot;
	logic                   stop;
	logic [7:0]             ebyte;
	logic                   mismatch;
	logic [31:0]            seen;

	always_comb begin
		phase_d = phase_q;
		als_d   = als_q;
		pcr_d   = pcr_q;
		seq_d   = seq_q;
		qual_d  = qual_q;
		total_d = total_q;
		halt_d  = halt_q;
		res[0]  = '0;
		res[1]  = '0;
		cnt     = 2'd0;
		slot    = 1'b0;
		stop    = 1'b0;
		ebyte   = data_byte;
		mismatch = (seq_q != qual_q);

		if (phase_q == PH_HALT) begin
			res[0].status = halt_q;
			cnt = 2'd1;
		end else if (end_of_input) begin
			cnt = 2'd1;
			if (phase_q == PH_HDR) begin
				pcr_d = 1'b0;
				als_d = 1'b1;
			end else if (phase_q == PH_QUAL && !als_q) begin
				pcr_d = 1'b0;
				if (mismatch) begin
					phase_d = PH_HALT;
					halt_d = ST_MISMATCH;
					res[0].status = ST_MISMATCH;
				end else begin
					if (total_q != '1)
						total_d = total_q + 1'b1;
					seq_d = '0;
					qual_d = '0;
					phase_d = PH_HDR;
					als_d = 1'b1;
					res[0].done = 1'b1;
				end
			end else begin
				phase_d = PH_HALT;
				halt_d = ST_TRUNC;
				pcr_d = 1'b0;
				res[0].status = ST_TRUNC;
			end
		end else if (phase_q == PH_HDR) begin
			if (data_byte == CH_LF) begin
				pcr_d = 1'b0;
				als_d = 1'b1;
			end else if (data_byte == CH_CR) begin
				pcr_d = 1'b1;
				als_d = 1'b0;
			end else if (data_byte == CH_AT && !pcr_q) begin
				phase_d = PH_NAME;
				als_d = 1'b0;
			end else begin
				phase_d = PH_HALT;
				halt_d = ST_NOAT;
				pcr_d = 1'b0;
				res[0].status = ST_NOAT;
				cnt = 2'd1;
			end
		end else if (data_byte == CH_LF) begin
			pcr_d = 1'b0;
			if (phase_q == PH_QUAL) begin
				cnt = 2'd1;
				if (mismatch) begin
					phase_d = PH_HALT;
					halt_d = ST_MISMATCH;
					res[0].status = ST_MISMATCH;
				end else begin
					if (total_q != '1)
						total_d = total_q + 1'b1;
					seq_d = '0;
					qual_d = '0;
					phase_d = PH_HDR;
					als_d = 1'b1;
					res[0].done = 1'b1;
				end
			end else begin
				phase_d = phase_q + 3'd1;
				als_d = 1'b1;
			end
		end else if (phase_q == PH_PLUS && als_q) begin
			als_d = 1'b0;
		end else begin
			als_d = 1'b0;
			// held CR goes out first, into slot 0
			if (pcr_q) begin
				pcr_d = 1'b0;
				cnt = 2'd1;
				slot = 1'b1;
				if ((phase_q == PH_SEQ && seq_d == '1) ||
				    (phase_q == PH_QUAL && qual_d == '1)) begin
					phase_d = PH_HALT;
					halt_d = ST_OVERFLOW;
					res[0].status = ST_OVERFLOW;
					stop = 1'b1;
				end else begin
					if (phase_q == PH_SEQ)
						seq_d = seq_d + 1'b1;
					if (phase_q == PH_QUAL)
						qual_d = qual_d + 1'b1;
					res[0].data = CH_CR;
					res[0].valid = 1'b1;
					res[0].tag = phase_q;
				end
			end
			if (!stop) begin
				if (data_byte == CH_CR) begin
					pcr_d = 1'b1;
				end else begin
					cnt = cnt + 2'd1;
					if ((phase_q == PH_SEQ && seq_d == '1) ||
					    (phase_q == PH_QUAL && qual_d == '1)) begin
						phase_d = PH_HALT;
						halt_d = ST_OVERFLOW;
						pcr_d = 1'b0;
						res[slot].status = ST_OVERFLOW;
					end else begin
						if (phase_q == PH_SEQ)
							seq_d = seq_d + 1'b1;
						if (phase_q == PH_QUAL)
							qual_d = qual_d + 1'b1;
						res[slot].data = ebyte;
						res[slot].valid = 1'b1;
						res[slot].tag = phase_q;
					end
				end
			end
		end
	end

	generate
		if (COUNT_BITS > 32) begin : g_sat
			assign seen = (|total_d[COUNT_BITS-1:32]) ? 32'hFFFF_FFFF : total_d[31:0];
		end else begin : g_ext
			assign seen = 32'(total_d);
		end
	endgenerate

	assign wr_en         = accept && (cnt != 2'd0);
	assign wr_entry.r0   = res[0];
	assign wr_entry.r1   = res[1];
	assign wr_entry.two  = (cnt == 2'd2);
	assign wr_entry.seen = seen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			als_q   <= 1'b1;
			pcr_q   <= 1'b0;
			seq_q   <= '0;
			qual_q  <= '0;
			total_q <= '0;
			halt_q  <= ST_OK;
		end else if (accept) begin
			phase_q <= phase_d;
			als_q   <= als_d;
			pcr_q   <= pcr_d;
			seq_q   <= seq_d;
			qual_q  <= qual_d;
			total_q <= total_d;
			halt_q  <= halt_d;
		end
	end

endmodule

/* hdl/frp_queue.sv */
// Short first-word-fall-through queue of entries between front and back.
module frp_queue import frp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  entry_t wr_entry,
	input  logic   rd_en,
	output entry_t rd_entry,
	output logic   q_full,
	output logic   q_empty
);

	entry_t               mem_q [0:QUEUE_DEPTH-1];
	logic [QIDX_BITS-1:0] wr_ptr_q;
	logic [QIDX_BITS-1:0] rd_ptr_q;
	logic [QIDX_BITS:0]   count_q;
	logic                 do_wr;
	logic                 do_rd;

	assign q_full   = (count_q == (QIDX_BITS+1)'(QUEUE_DEPTH));
	assign q_empty  = (count_q == '0);
	assign do_wr    = wr_en && !q_full;
	assign do_rd    = rd_en && !q_empty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* hdl/frp_back.sv */
// Back end: hands out the one or two results of the head entry, one beat each.
module frp_back import frp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  entry_t      head,
	input  logic        q_empty,
	output logic        rd_en,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        out_valid,
	output logic [2:0]  field_tag,
	output logic        record_done,
	output logic [2:0]  status,
	output logic [31:0] records_seen,
	output logic        last
);

	logic    sel_q;
	result_t cur;
	logic    take;

	assign cur          = sel_q ? head.r1 : head.r0;
	assign empty        = q_empty;
	assign out_byte     = cur.data;
	assign out_valid    = cur.valid;
	assign field_tag    = cur.tag;
	assign record_done  = cur.done;
	assign status       = cur.status;
	assign records_seen = head.seen;
	assign last         = sel_q || !head.two;
	assign take         = pop && !q_empty;
	assign rd_en        = take && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (take) begin
			sel_q <= !last;
		end
	end

endmodule

/* hdl/fastq_record_parser.sv */
// Top level of the FASTQ record parser.
// Takes one FASTQ text byte per beat and tags each kept byte as name, sequence,
// plus suffix or quality; an input beat gives zero, one or two results. The front
// end accepts one input beat per cycle while the four-entry result queue has room,
// and the back end delivers one result per cycle while pop is held and the queue is
// not empty, so the result port keeps up with a byte stream until bytes that give two
// results (a held CR sent out before the next byte) make the single result port the
// limit. Errors (missing '@', length mismatch, truncation, length overflow) halt the
// parser, and every later input gives one empty result with that status until reset.
module fastq_record_parser import frp_pkg::*; #(
	parameter int LENGTH_BITS = 16,
	parameter int COUNT_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_input,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        out_valid,
	output logic [2:0]  field_tag,
	output logic        record_done,
	output logic [2:0]  status,
	output logic [31:0] records_seen,
	output logic        last
);

	logic   accept;
	logic   wr_en;
	entry_t wr_entry;
	entry_t head;
	logic   rd_en;
	logic   q_full;
	logic   q_empty;

	assign full   = q_full;
	assign accept = push && !q_full;

	frp_front #(
		.LENGTH_BITS(LENGTH_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (data_byte),
		.end_of_input(end_of_input),
		.wr_en       (wr_en),
		.wr_entry    (wr_entry)
	);

	frp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_entry(wr_entry),
		.rd_en   (rd_en),
		.rd_entry(head),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	frp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_empty     (q_empty),
		.rd_en       (rd_en),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.out_valid   (out_valid),
		.field_tag   (field_tag),
		.record_done (record_done),
		.status      (status),
		.records_seen(records_seen),
		.last        (last)
	);

endmodule
